[sv/dhglcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhglcd_pkg
// Shared types, command codes and address tables for the dual-half graphic
// LCD controller core.
// ----------------------------------------------------------------------------
package dhglcd_pkg;

   // geometry of one controller half
   localparam int COLUMNS = 64;
   localparam int PAGES   = 8;
   localparam int HALVES  = 2;

   localparam int COL_W  = $clog2(COLUMNS);
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LINE_W = 6;

   // bus access kinds
   typedef enum logic [1:0] {
      KIND_CMD    = 2'd0,
      KIND_STATUS = 2'd1,
      KIND_WRITE  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   // command bytes and masks
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h3F;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h3E;
   localparam logic [7:0] CMD_PAGE        = 8'hB8;
   localparam logic [7:0] CMD_PAGE_MASK   = 8'hF8;
   localparam logic [7:0] CMD_COLUMN      = 8'h40;
   localparam logic [7:0] CMD_START_LINE  = 8'hC0;
   localparam logic [7:0] CMD_FIELD_MASK  = 8'hC0;
   localparam logic [7:0] STATUS_OFF_BIT  = 8'h20;

   // column and page fields folded into range
   typedef logic [COL_W-1:0]  col_tab_type  [64];
   typedef logic [PAGE_W-1:0] page_tab_type [8];

   function automatic col_tab_type col_tab_build();
      col_tab_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = COL_W'(i % COLUMNS);
      end
      return t;
   endfunction

   function automatic page_tab_type page_tab_build();
      page_tab_type t;
      for (int i = 0; i < 8; i++) begin
         t[i] = PAGE_W'(i % PAGES);
      end
      return t;
   endfunction

   localparam col_tab_type  COL_TAB  = col_tab_build();
   localparam page_tab_type PAGE_TAB = page_tab_build();

endpackage
`default_nettype wire

[sv/dhglcd_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhglcd_req_if
// Request channel: one bus access with half selects.
// ----------------------------------------------------------------------------
interface dhglcd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic       sel_left;
   logic       sel_right;
   logic [7:0] bus_data;

   modport source (output valid, output kind, output sel_left, output sel_right,
                   output bus_data, input ready);
   modport sink   (input valid, input kind, input sel_left, input sel_right,
                   input bus_data, output ready);
endinterface
`default_nettype wire

[sv/dhglcd_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhglcd_rsp_if
// Response channel: read data and its valid flag, one per request.
// ----------------------------------------------------------------------------
interface dhglcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       read_valid;

   modport source (output valid, output read_data, output read_valid, input ready);
   modport sink   (input valid, input read_data, input read_valid, output ready);
endinterface
`default_nettype wire

[sv/dual_half_graphic_lcd_controller_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_half_graphic_lcd_controller_core
// Bus-side model of a two-half 128x64 graphic LCD controller pair: commands,
// pixel data writes, status reads and latched data reads.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                 handshake
//  req_chan  in         kind, sel_left, sel_right, bus_data     valid/ready
//  rsp_chan  out        read_data, read_valid                   valid/ready
//
//  one request per cycle while req_chan.ready is high; each request makes one
//  response in the next cycle, held in an output register
//  each half owns one pixel RAM; a data read reloads the output latch through
//  that RAM's registered read port, whose data register serves as the latch
//  after reset the pixel RAMs are cleared, all PAGES*COLUMNS (512) entries,
//  with req_chan.ready low
//  a stalled response holds the request side only while the output register
//  is full and not taken
// ----------------------------------------------------------------------------
module dual_half_graphic_lcd_controller_core (
   input  wire logic   clock,
   input  wire logic   reset,
   dhglcd_req_if.sink   req_chan,
   dhglcd_rsp_if.source rsp_chan
);
   import dhglcd_pkg::*;

   logic                  accept;
   kind_type              kind;
   logic [HALVES-1:0]     half_sel;
   logic                  any_sel;

   logic                  clearing_ff;
   logic [ADDR_W-1:0]     clr_addr_ff;

   logic [PAGE_W-1:0]     page_ff    [HALVES];
   logic [COL_W-1:0]      col_ff     [HALVES];
   logic                  disp_ff    [HALVES];
   logic [LINE_W-1:0]     line_ff    [HALVES];
   logic                  pend_ff    [HALVES];
   logic [7:0]            ram_q      [HALVES];
   logic [7:0]            latch      [HALVES];

   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff;
   logic                  rsp_rvalid_ff;
   logic [7:0]            rsp_data_in;
   logic                  rsp_rvalid_in;
   logic                  disp_first;
   logic [7:0]            latch_first;

   assign kind     = kind_type'(req_chan.kind);
   assign req_chan.ready = !clearing_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept   = req_chan.valid && req_chan.ready;

   assign half_sel[0] = req_chan.sel_left;
   generate
      if (HALVES > 1) begin : g_right
         assign half_sel[HALVES-1] = req_chan.sel_right;
      end
   endgenerate
   assign any_sel = |half_sel;

   // clearing pass over the pixel RAMs after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   generate
      for (genvar h = 0; h < HALVES; h++) begin : g_half
         logic              hit;
         logic [COL_W-1:0]  col_next;
         logic [ADDR_W-1:0] cell_addr;
         logic              ram_wr;
         logic              ram_rd;
         logic [ADDR_W-1:0] ram_addr;

         assign hit      = accept && half_sel[h];
         assign col_next = (col_ff[h] == COL_W'(COLUMNS - 1)) ? '0 : col_ff[h] + 1'b1;
         assign cell_addr = ADDR_W'(page_ff[h]) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff[h]);

         assign ram_wr   = clearing_ff || (hit && kind == KIND_WRITE);
         assign ram_rd   = !clearing_ff && hit && kind == KIND_READ;
         assign ram_addr = clearing_ff ? clr_addr_ff : cell_addr;

         // latch reads zero until the first data read loads it
         assign latch[h] = pend_ff[h] ? ram_q[h] : '0;

         always_ff @(posedge clock) begin
            if (reset) begin
               page_ff[h] <= '0;
               col_ff[h]  <= '0;
               disp_ff[h] <= 1'b0;
               line_ff[h] <= '0;
               pend_ff[h] <= 1'b0;
            end else if (hit) begin
               unique case (kind)
                  KIND_CMD: begin
                     if (req_chan.bus_data == CMD_DISPLAY_ON) begin
                        disp_ff[h] <= 1'b1;
                     end else if (req_chan.bus_data == CMD_DISPLAY_OFF) begin
                        disp_ff[h] <= 1'b0;
                     end else if ((req_chan.bus_data & CMD_PAGE_MASK) == CMD_PAGE) begin
                        page_ff[h] <= PAGE_TAB[req_chan.bus_data[2:0]];
                     end else if ((req_chan.bus_data & CMD_FIELD_MASK) == CMD_COLUMN) begin
                        col_ff[h] <= COL_TAB[req_chan.bus_data[5:0]];
                     end else if ((req_chan.bus_data & CMD_FIELD_MASK) == CMD_START_LINE) begin
                        line_ff[h] <= req_chan.bus_data[LINE_W-1:0];
                     end
                  end
                  KIND_WRITE: begin
                     col_ff[h] <= col_next;
                  end
                  KIND_READ: begin
                     col_ff[h]  <= col_next;
                     pend_ff[h] <= 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         dhglcd_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
         ) u_ram (
            .clock   (clock),
            .wr_en   (ram_wr),
            .rd_en   (ram_rd),
            .addr    (ram_addr),
            .wr_data (clearing_ff ? 8'h00 : req_chan.bus_data),
            .rd_data (ram_q[h])
         );
      end
   endgenerate

   // reads report the left half when both are selected
   assign disp_first  = half_sel[0] ? disp_ff[0] : disp_ff[HALVES-1];
   assign latch_first = half_sel[0] ? latch[0]   : latch[HALVES-1];

   always_comb begin
      rsp_data_in   = '0;
      rsp_rvalid_in = 1'b0;
      if (any_sel) begin
         unique case (kind)
            KIND_STATUS: begin
               rsp_data_in   = disp_first ? 8'h00 : STATUS_OFF_BIT;
               rsp_rvalid_in = 1'b1;
            end
            KIND_READ: begin
               rsp_data_in   = latch_first;
               rsp_rvalid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_rvalid_ff <= rsp_rvalid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_data  = rsp_data_ff;
   assign rsp_chan.read_valid = rsp_rvalid_ff;

   // writes and commands never give read data
   a_write_no_read: assert property (@(posedge clock) disable iff (reset)
      accept && (kind == KIND_CMD || kind == KIND_WRITE)
      |=> rsp_chan.valid && !rsp_chan.read_valid && rsp_chan.read_data == 8'h00)
      else $error("write request produced read data");

   // a request with no half selected gives no read
   a_nosel_no_read: assert property (@(posedge clock) disable iff (reset)
      accept && !req_chan.sel_left && !req_chan.sel_right |=> !rsp_chan.read_valid)
      else $error("read valid without a selected half");

   // the left half's column stays within the half
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff[0] <= COL_W'(COLUMNS - 1))
      else $error("column address out of range");

   // clearing ends only after the last entry
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      $fell(clearing_ff) |-> $past(clr_addr_ff) == ADDR_W'(DEPTH - 1))
      else $error("clearing pass ended early");

endmodule
`default_nettype wire

[sv/dhglcd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dhglcd_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module dhglcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[addr];
      end
   end
endmodule
`default_nettype wire
